### hw/rtl/aff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aff_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned MAT_SIZE    = 6;

  localparam int unsigned IDX_A  = 0;
  localparam int unsigned IDX_B  = 1;
  localparam int unsigned IDX_C  = 2;
  localparam int unsigned IDX_D  = 3;
  localparam int unsigned IDX_TX = 4;
  localparam int unsigned IDX_TY = 5;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef val_t mat_t [MAT_SIZE];

  typedef enum logic [2:0] {
    OP_INIT    = 3'd0,
    OP_LOAD    = 3'd1,
    OP_MAT_MUL = 3'd2,
    OP_SHIFT   = 3'd3,
    OP_STRETCH = 3'd4,
    OP_POINT   = 3'd5,
    OP_DIST    = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    CFG_DEFAULT_A  = 3'd0,
    CFG_DEFAULT_B  = 3'd1,
    CFG_DEFAULT_C  = 3'd2,
    CFG_DEFAULT_D  = 3'd3,
    CFG_DEFAULT_TX = 3'd4,
    CFG_DEFAULT_TY = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0] op;
    val_t       in_x;
    val_t       in_y;
    val_t       in_a;
    val_t       in_b;
    val_t       in_c;
    val_t       in_d;
    val_t       in_tx;
    val_t       in_ty;
  } in_item_t;

  typedef struct packed {
    val_t out_x;
    val_t out_y;
    val_t cur_a;
    val_t cur_b;
    val_t cur_c;
    val_t cur_d;
    val_t cur_tx;
    val_t cur_ty;
    logic saturated;
  } out_item_t;

endpackage

`default_nettype wire

### hw/rtl/affine_ctm_transform_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// 2D affine current-matrix unit, signed fixed point.
// Input channel (in_valid_i/in_ready_o, in_item_i): op plus point and
// operand matrix. Output channel (out_valid_o/out_ready_i, out_item_o):
// transformed x,y, the matrix after the item, and a saturation flag.
// Config channel (cfg_valid_i/cfg_ready_o): writes the default matrix used
// by the init op; always ready, indexes past the last register are dropped.
// Pipeline: an accepted item sits in the input register, and the
// multiply/add/saturate pass on it is loaded into the result register
// once that register can advance. Throughput: one item per cycle while
// the output is not stalled; the held matrix is updated in the same
// cycle that the result register loads, so the next item sees it.
// Reset: current and default matrices become identity, no item in flight.
// Stall: while out_ready_i is low the result is held; one more item can be
// taken into the input register, then in_ready_o drops.
module affine_ctm_transform_unit import aff_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  val_t       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o
);

  localparam val_t One = val_t'(1) << FracBits;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  mat_t      cur_q;
  mat_t      dflt_q;
  out_item_t res;
  logic      adv;

  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = !in_valid_q || adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  aff_datapath #(
    .FracBits(FracBits)
  ) u_datapath (
    .item_i(in_item_q),
    .cur_i (cur_q),
    .dflt_i(dflt_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
    if (adv && in_valid_q) begin
      out_item_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q[IDX_A]  <= One;
      cur_q[IDX_B]  <= '0;
      cur_q[IDX_C]  <= '0;
      cur_q[IDX_D]  <= One;
      cur_q[IDX_TX] <= '0;
      cur_q[IDX_TY] <= '0;
    end else if (adv && in_valid_q) begin
      cur_q[IDX_A]  <= res.cur_a;
      cur_q[IDX_B]  <= res.cur_b;
      cur_q[IDX_C]  <= res.cur_c;
      cur_q[IDX_D]  <= res.cur_d;
      cur_q[IDX_TX] <= res.cur_tx;
      cur_q[IDX_TY] <= res.cur_ty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q[IDX_A]  <= One;
      dflt_q[IDX_B]  <= '0;
      dflt_q[IDX_C]  <= '0;
      dflt_q[IDX_D]  <= One;
      dflt_q[IDX_TX] <= '0;
      dflt_q[IDX_TY] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEFAULT_A:  dflt_q[IDX_A]  <= cfg_data_i;
        CFG_DEFAULT_B:  dflt_q[IDX_B]  <= cfg_data_i;
        CFG_DEFAULT_C:  dflt_q[IDX_C]  <= cfg_data_i;
        CFG_DEFAULT_D:  dflt_q[IDX_D]  <= cfg_data_i;
        CFG_DEFAULT_TX: dflt_q[IDX_TX] <= cfg_data_i;
        CFG_DEFAULT_TY: dflt_q[IDX_TY] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/aff_dot.sv
`timescale 1ns / 1ps
`default_nettype none

module aff_dot import aff_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS
) (
  input  val_t p_i,
  input  val_t q_i,
  input  val_t r_i,
  input  val_t s_i,
  input  val_t t_i,
  input  logic use_t_i,
  output val_t res_o,
  output logic sat_o
);

  localparam int unsigned PW = 2 * VALUE_WIDTH;
  localparam int unsigned SW = PW - FracBits + 2;
  localparam logic signed [SW-1:0] MaxV =
    {{(SW - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] MinV = ~MaxV;

  logic signed [PW-1:0] pq;
  logic signed [PW-1:0] rs;
  logic signed [PW-1:0] pq_sh;
  logic signed [PW-1:0] rs_sh;
  logic signed [SW-1:0] t_ext;
  logic signed [SW-1:0] sum;

  assign pq    = PW'(p_i) * PW'(q_i);
  assign rs    = PW'(r_i) * PW'(s_i);
  // arithmetic shift floors toward minus infinity
  assign pq_sh = pq >>> FracBits;
  assign rs_sh = rs >>> FracBits;
  assign t_ext = use_t_i ? SW'(t_i) : SW'(0);
  assign sum   = SW'(pq_sh) + SW'(rs_sh) + t_ext;

  always_comb begin
    sat_o = 1'b0;
    res_o = sum[VALUE_WIDTH-1:0];
    if (sum > MaxV) begin
      sat_o = 1'b1;
      res_o = MaxV[VALUE_WIDTH-1:0];
    end else if (sum < MinV) begin
      sat_o = 1'b1;
      res_o = MinV[VALUE_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/aff_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module aff_datapath import aff_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS
) (
  input  in_item_t  item_i,
  input  mat_t      cur_i,
  input  mat_t      dflt_i,
  output out_item_t res_o
);

  localparam val_t One = val_t'(1) << FracBits;

  mat_t                opm;
  mat_t                itm;
  mat_t                dres;
  mat_t                nxt;
  logic [MAT_SIZE-1:0] dsat;
  logic                use_t;
  val_t                ox;
  val_t                oy;
  logic                sat;

  assign itm[IDX_A]  = item_i.in_a;
  assign itm[IDX_B]  = item_i.in_b;
  assign itm[IDX_C]  = item_i.in_c;
  assign itm[IDX_D]  = item_i.in_d;
  assign itm[IDX_TX] = item_i.in_tx;
  assign itm[IDX_TY] = item_i.in_ty;

  // point ops reuse the translation row: x' = x*a + y*c + tx (dist drops tx)
  always_comb begin
    opm   = itm;
    use_t = 1'b1;
    case (item_i.op)
      OP_SHIFT: begin
        opm[IDX_A]  = One;
        opm[IDX_B]  = '0;
        opm[IDX_C]  = '0;
        opm[IDX_D]  = One;
        opm[IDX_TX] = item_i.in_x;
        opm[IDX_TY] = item_i.in_y;
      end
      OP_STRETCH: begin
        opm[IDX_A]  = item_i.in_x;
        opm[IDX_B]  = '0;
        opm[IDX_C]  = '0;
        opm[IDX_D]  = item_i.in_y;
        opm[IDX_TX] = '0;
        opm[IDX_TY] = '0;
      end
      OP_POINT: begin
        opm[IDX_TX] = item_i.in_x;
        opm[IDX_TY] = item_i.in_y;
      end
      OP_DIST: begin
        opm[IDX_TX] = item_i.in_x;
        opm[IDX_TY] = item_i.in_y;
        use_t       = 1'b0;
      end
      default: begin
      end
    endcase
  end

  for (genvar k = 0; k < MAT_SIZE; k++) begin : g_dot
    localparam int unsigned Row = k / 2;
    localparam int unsigned Col = k % 2;
    aff_dot #(
      .FracBits(FracBits)
    ) u_dot (
      .p_i    (opm[2*Row]),
      .q_i    (cur_i[Col]),
      .r_i    (opm[2*Row+1]),
      .s_i    (cur_i[Col+2]),
      .t_i    (cur_i[IDX_TX+Col]),
      .use_t_i(use_t && (Row == 2)),
      .res_o  (dres[k]),
      .sat_o  (dsat[k])
    );
  end

  always_comb begin
    nxt = cur_i;
    ox  = '0;
    oy  = '0;
    sat = 1'b0;
    case (item_i.op) inside
      OP_INIT: nxt = dflt_i;
      OP_LOAD: nxt = itm;
      OP_MAT_MUL, OP_SHIFT, OP_STRETCH: begin
        nxt = dres;
        sat = |dsat;
      end
      OP_POINT, OP_DIST: begin
        ox  = dres[IDX_TX];
        oy  = dres[IDX_TY];
        sat = dsat[IDX_TX] | dsat[IDX_TY];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.out_x     = ox;
    res_o.out_y     = oy;
    res_o.cur_a     = nxt[IDX_A];
    res_o.cur_b     = nxt[IDX_B];
    res_o.cur_c     = nxt[IDX_C];
    res_o.cur_d     = nxt[IDX_D];
    res_o.cur_tx    = nxt[IDX_TX];
    res_o.cur_ty    = nxt[IDX_TY];
    res_o.saturated = sat;
  end

endmodule

`default_nettype wire
